[hw/rtl/sbfp_pkg.sv]
// Shared definitions for the serial bus bridge frame parser.
// Holds the frame phase codes, result kind codes and frame command bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbfp_pkg;

  // Frame phase codes (plain state vector)
  localparam logic [2:0] PhCmd   = 3'd0;
  localparam logic [2:0] PhLen   = 3'd1;
  localparam logic [2:0] PhAddr0 = 3'd2;
  localparam logic [2:0] PhAddr1 = 3'd3;
  localparam logic [2:0] PhAddr2 = 3'd4;
  localparam logic [2:0] PhAddr3 = 3'd5;
  localparam logic [2:0] PhData  = 3'd6;

  // Command bytes
  localparam logic [7:0] CmdWrite = 8'h00;
  localparam logic [7:0] CmdRead  = 8'h01;

  // Result kinds
  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindRead  = 2'd1,
    KindEmpty = 2'd2
  } kind_e;

endpackage : sbfp_pkg

`default_nettype wire

[hw/rtl/serial_bus_bridge_frame_parser_top.sv]
// Top level of the serial bus bridge frame parser.
// Frame state machine plus a single output register; uses sbfp_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid_i/in_ready_o | in_byte_i
//   out     | output    | out_valid_o/out_ready_i | kind_o, bus_address_o, byte_offset_o,
//           |           |                       | write_byte_o, frame_length_o, last_o
//
// One byte per cycle while the output is not stalled: each accepted item is parsed in
// the cycle it is taken and any result lands in the output register at that edge.
// The output register sets the rate: a new item is taken whenever it is empty or
// being drained in the same cycle. Reset puts the parser back to awaiting a command
// and empties the output register. A stall on the output side holds the result and
// stops input acceptance until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module serial_bus_bridge_frame_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output sbfp_pkg::kind_e  kind_o,
  output logic [31:0]      bus_address_o,
  output logic [7:0]       byte_offset_o,
  output logic [7:0]       write_byte_o,
  output logic [7:0]       frame_length_o,
  output logic             last_o
);
  import sbfp_pkg::*;

  // Parser state
  logic [2:0]  phase_q, phase_d;
  logic        is_read_q, is_read_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  count_q, count_d;

  // Output register
  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [31:0] out_addr_q;
  logic [7:0]  offset_q, offset_d;
  logic [7:0]  wbyte_q, wbyte_d;
  logic [7:0]  out_len_q;
  logic        last_q, last_d;

  logic        emit;
  logic        in_fire;
  logic [8:0]  count_next;

  // Accept while the output register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_next = {1'b0, count_q} + 9'd1;

  // Parse one byte
  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    addr_d    = addr_q;
    len_d     = len_q;
    count_d   = count_q;
    emit      = 1'b0;
    kind_d    = KindWrite;
    offset_d  = 8'd0;
    wbyte_d   = 8'd0;
    last_d    = 1'b0;
    unique case (phase_q)
      PhLen: begin
        len_d   = in_byte_i;
        count_d = 8'd0;
        addr_d  = 32'd0;
        phase_d = PhAddr0;
      end
      PhAddr0, PhAddr1, PhAddr2: begin
        addr_d  = {addr_q[23:0], in_byte_i};
        phase_d = phase_q + 3'd1;
      end
      PhAddr3: begin
        addr_d = {addr_q[23:0], in_byte_i};
        if (is_read_q) begin
          emit    = 1'b1;
          kind_d  = KindRead;
          last_d  = 1'b1;
          phase_d = PhCmd;
        end else if (len_q == 8'd0) begin
          emit    = 1'b1;
          kind_d  = KindEmpty;
          last_d  = 1'b1;
          phase_d = PhCmd;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        emit     = 1'b1;
        kind_d   = KindWrite;
        offset_d = count_q;
        wbyte_d  = in_byte_i;
        last_d   = (count_next >= {1'b0, len_q});
        count_d  = count_next[7:0];
        if (last_d) begin
          phase_d = PhCmd;
        end
      end
      default: begin
        // awaiting a command; drop anything that is not read or write
        if (in_byte_i == CmdWrite || in_byte_i == CmdRead) begin
          is_read_d = in_byte_i[0];
          phase_d   = PhLen;
        end else begin
          phase_d = PhCmd;
        end
      end
    endcase
  end

  // Advance parser state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhCmd;
      is_read_q <= 1'b0;
      addr_q    <= 32'd0;
      len_q     <= 8'd0;
      count_q   <= 8'd0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      addr_q    <= addr_d;
      len_q     <= len_d;
      count_q   <= count_d;
    end
  end

  // Output valid: set on a new result, clear when drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q     <= kind_d;
      out_addr_q <= addr_d;
      offset_q   <= offset_d;
      wbyte_q    <= wbyte_d;
      out_len_q  <= len_q;
      last_q     <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign bus_address_o  = out_addr_q;
  assign byte_offset_o  = offset_q;
  assign write_byte_o   = wbyte_q;
  assign frame_length_o = out_len_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // Unused phase code is never reached
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhData)
    else $error("parser phase out of range");

  // Read requests and empty commits close their frame with zero offset and data
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KindRead || kind_q == KindEmpty)
      |-> last_q && offset_q == 8'd0 && wbyte_q == 8'd0)
    else $error("read or empty commit result malformed");

  // Empty commit only for a zero-length frame
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KindEmpty |-> out_len_q == 8'd0)
    else $error("empty commit with non-zero length");

  // Write data stays inside the payload and is marked last on its final byte
  a_write_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KindWrite
      |-> offset_q < out_len_q && last_q == ({1'b0, offset_q} + 9'd1 == {1'b0, out_len_q}))
    else $error("write data offset or last flag wrong");

  // A stalled result is neither lost nor overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_addr_q) && $stable(offset_q))
    else $error("stalled result disturbed");
`endif

endmodule : serial_bus_bridge_frame_parser_top

`default_nettype wire
